// ===== design/ucsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the uniform color span compositor.
// Depends on nothing; every other file imports it.
package ucsc_pkg;

    localparam int STORE_AW = 16;
    localparam int STORE_WORDS = 1 << STORE_AW;
    localparam int ADDR_W = 18;
    localparam int CNT_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [15:0] BLEND_ONE = 16'd65025;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd2;

    localparam logic [31:0] SOLID_RESET = 32'h0000_0000;
    localparam logic [63:0] WIDE_RESET = 64'h0080_0080_0080_0080;
    localparam logic [8:0] STRIDE_RESET = 9'd256;

    localparam logic [1:0] CMD_SPAN = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] coverage;
        logic [7:0] run_length;
        logic [31:0] pixel_value;
    } t_request;

    typedef struct packed {
        logic [31:0] read_value;
        logic range_error;
    } t_result;

endpackage

// ===== design/uniform_color_span_compositor.sv =====
`timescale 1ns / 1ps
// Top level of the span compositor: pixel store, command sequencer and blend logic.
// Depends on ucsc_pkg.
//
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with o_done, and the receiver cannot stall it. The pixel
// store is one synchronous memory with one read and one write port, and it moves one
// pixel per cycle. A span addresses run_length pixels, plus one when coverage is nonzero;
// a load or read addresses one pixel and an unknown command none. The result comes
// sooner when the last pixel lies outside the store, as that pixel is not written.
// The store has no reset; a pixel must be loaded before it is read.
module uniform_color_span_compositor
    import ucsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_request              i_request,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic [31:0] blend_partial(
        input logic [31:0] d,
        input logic [31:0] s,
        input logic [7:0]  c,
        input logic [7:0]  ia
    );
        logic [16:0] ch;
        logic [31:0] res;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            ch = {1'b0, {8'b0, s[8*k +: 8]} * {8'b0, c}}
               + {1'b0, {8'b0, d[8*k +: 8]} * {8'b0, ia}};
            res = res | (32'(ch[16:8]) << (8 * k));
        end
        return res;
    endfunction

    function automatic logic [31:0] blend_full(
        input logic [31:0] d,
        input logic [63:0] w,
        input logic [7:0]  ia
    );
        logic [15:0] sum;
        logic [31:0] res;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            sum = w[16*k +: 16] + {8'b0, d[8*k +: 8]} * {8'b0, ia};
            res[8*k +: 8] = sum[15:8];
        end
        return res;
    endfunction

    logic [31:0] mem [STORE_WORDS];

    t_state r_state, n_state;
    t_request r_req;
    logic [31:0] r_solid;
    logic [63:0] r_wide;
    logic [8:0] r_stride;

    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0] r_cnt;
    logic r_first;
    logic [7:0] r_ia_part;
    logic r_err;
    logic [31:0] r_rdval;

    logic r_s_valid;
    logic r_s_first;
    logic [STORE_AW-1:0] r_s_addr;
    logic [31:0] r_mem_q;

    logic r_done;
    t_result r_result;

    logic w_issue;
    logic w_finish;
    logic w_in_rng;
    logic w_is_span;
    logic w_cov_nz;
    logic [16:0] w_row;
    logic [ADDR_W-1:0] w_base;
    logic [15:0] w_alpha_cov;
    logic [15:0] w_ia_full;
    logic [7:0] w_ia8;
    logic w_we;
    logic [31:0] w_wdata;

    assign busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_result = r_result;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_cnt == '0 && !r_s_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_issue = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_RUN: begin
                w_issue = (r_cnt != '0);
                w_finish = (r_cnt == '0) && !r_s_valid;
            end
            default: begin
                w_issue = 1'b0;
                w_finish = 1'b0;
            end
        endcase
    end

    assign w_in_rng = (r_addr[ADDR_W-1:STORE_AW] == '0);
    assign w_is_span = (r_req.command == CMD_SPAN);
    assign w_cov_nz = (r_req.coverage != 8'd0);
    assign w_row = {9'b0, r_req.y_pos} * {8'b0, r_stride};
    assign w_base = {1'b0, w_row} + {10'b0, r_req.x_pos};
    assign w_alpha_cov = {8'b0, r_solid[31:24]} * {8'b0, r_req.coverage};
    assign w_ia_full = BLEND_ONE - w_alpha_cov;
    assign w_ia8 = ALPHA_OPAQUE - r_solid[31:24];

    always_comb begin
        w_we = 1'b0;
        w_wdata = r_req.pixel_value;
        if (r_s_valid) begin
            case (r_req.command)
                CMD_LOAD: begin
                    w_we = 1'b1;
                    w_wdata = r_req.pixel_value;
                end
                CMD_SPAN: begin
                    w_we = 1'b1;
                    if (r_s_first) begin
                        w_wdata = blend_partial(r_mem_q, r_solid, r_req.coverage, r_ia_part);
                    end else if (r_solid[31:24] == ALPHA_OPAQUE) begin
                        w_wdata = r_solid;
                    end else begin
                        w_wdata = blend_full(r_mem_q, r_wide, w_ia8);
                    end
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue && w_in_rng) begin
            r_mem_q <= mem[r_addr[STORE_AW-1:0]];
        end
        if (w_we) begin
            mem[r_s_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_solid <= SOLID_RESET;
            r_wide <= WIDE_RESET;
            r_stride <= STRIDE_RESET;
            r_cnt <= '0;
            r_s_valid <= 1'b0;
            r_done <= 1'b0;
            r_err <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= w_finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SOLID_COLOR: r_solid <= i_cfg_data[31:0];
                    CFG_WIDE_COLOR:  r_wide <= i_cfg_data;
                    CFG_ROW_STRIDE:  r_stride <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_SETUP) begin
                r_err <= 1'b0;
                r_first <= w_is_span && w_cov_nz;
                case (r_req.command)
                    CMD_SPAN: begin
                        r_cnt <= {1'b0, r_req.run_length} + {8'b0, w_cov_nz};
                    end
                    CMD_LOAD, CMD_READ: begin
                        r_cnt <= CNT_W'(1);
                    end
                    default: begin
                        r_cnt <= '0;
                    end
                endcase
            end else if (w_issue) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_first <= 1'b0;
                if (!w_in_rng) begin
                    r_err <= 1'b1;
                end
            end
            r_s_valid <= w_issue && w_in_rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_request;
        end
        if (r_state == ST_SETUP) begin
            r_addr <= (w_is_span && !w_cov_nz) ? w_base + ADDR_W'(1) : w_base;
            r_ia_part <= w_ia_full[15:8];
            r_rdval <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        r_s_first <= r_first;
        r_s_addr <= r_addr[STORE_AW-1:0];
        if (r_s_valid && r_req.command == CMD_READ) begin
            r_rdval <= r_mem_q;
        end
        if (w_finish) begin
            r_result.read_value <= r_rdval;
            r_result.range_error <= r_err;
        end
    end

endmodule

// ===== design/ucsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the span compositor and its bind to the top level.
// Depends on ucsc_pkg and uniform_color_span_compositor.
module ucsc_checker
    import ucsc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request was taken");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while the block is busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without a result");

endmodule

bind uniform_color_span_compositor ucsc_checker u_ucsc_checker (.*);
